/* hdl/mcprng_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcprng_pkg
// Constants, control word layout and microprogram for the multiply-with-carry
// uniform generator.
// ----------------------------------------------------------------------------
package mcprng_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PROD_W  = 2 * WORD_W;
  localparam int unsigned NWORDS  = 5;
  localparam int unsigned PC_W    = 4;
  localparam int unsigned CNT_W   = 5;

  localparam logic [WORD_W-1:0] SEED_MULT = 32'd29943829;
  localparam logic [WORD_W-1:0] COEF_W3   = 32'd2111111111;
  localparam logic [WORD_W-1:0] COEF_W2   = 32'd1492;
  localparam logic [WORD_W-1:0] COEF_W1   = 32'd1776;
  localparam logic [WORD_W-1:0] COEF_W0   = 32'd5115;

  // loop counts, stored as passes minus one
  localparam logic [CNT_W-1:0] SEED_LAST = CNT_W'(NWORDS - 1);
  localparam logic [CNT_W-1:0] WARM_LAST = CNT_W'(19 - 1);

  // multiplier operand selects
  localparam logic [2:0] MS_NONE = 3'd0;
  localparam logic [2:0] MS_SEED = 3'd1;
  localparam logic [2:0] MS_W3   = 3'd2;
  localparam logic [2:0] MS_W2   = 3'd3;
  localparam logic [2:0] MS_W1   = 3'd4;
  localparam logic [2:0] MS_W0   = 3'd5;
  localparam logic [2:0] MS_SPAN = 3'd6;

  // accumulator operations
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  // sequencing conditions
  localparam logic [1:0] C_NEXT = 2'd0;
  localparam logic [1:0] C_LOOP = 2'd1;
  localparam logic [1:0] C_KIND = 2'd2;
  localparam logic [1:0] C_FIN  = 2'd3;

  // request modes
  localparam logic [1:0] MODE_SEED  = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_EQUAL = 2'd2;

  // request kinds on the input tuser
  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  // program addresses
  localparam logic [PC_W-1:0] S_SEED_MUL = 4'd0;
  localparam logic [PC_W-1:0] S_SEED_WR  = 4'd1;
  localparam logic [PC_W-1:0] S_GEN_W3   = 4'd2;
  localparam logic [PC_W-1:0] S_GEN_W2   = 4'd3;
  localparam logic [PC_W-1:0] S_GEN_W1   = 4'd4;
  localparam logic [PC_W-1:0] S_GEN_W0   = 4'd5;
  localparam logic [PC_W-1:0] S_GEN_CMT  = 4'd6;
  localparam logic [PC_W-1:0] S_KIND     = 4'd7;
  localparam logic [PC_W-1:0] S_SPAN_MUL = 4'd8;
  localparam logic [PC_W-1:0] S_FIN      = 4'd9;

  typedef struct packed {
    logic [2:0]      mul_sel;
    logic [1:0]      acc_op;
    logic            commit;
    logic            seed_wr;
    logic            reload;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uc;
    uc = '{mul_sel: MS_NONE, acc_op: ACC_HOLD, commit: 1'b0, seed_wr: 1'b0,
           reload: 1'b0, cond: C_NEXT, target: S_SEED_MUL};
    unique case (pc)
      S_SEED_MUL: uc.mul_sel = MS_SEED;
      S_SEED_WR: begin
        uc.seed_wr = 1'b1;
        uc.reload  = 1'b1;
        uc.cond    = C_LOOP;
        uc.target  = S_SEED_MUL;
      end
      S_GEN_W3: begin
        uc.mul_sel = MS_W3;
        uc.acc_op  = ACC_LOAD;
      end
      S_GEN_W2: begin
        uc.mul_sel = MS_W2;
        uc.acc_op  = ACC_ADD;
      end
      S_GEN_W1: begin
        uc.mul_sel = MS_W1;
        uc.acc_op  = ACC_ADD;
      end
      S_GEN_W0: begin
        uc.mul_sel = MS_W0;
        uc.acc_op  = ACC_ADD;
      end
      S_GEN_CMT: begin
        uc.commit = 1'b1;
        uc.cond   = C_LOOP;
        uc.target = S_GEN_W3;
      end
      S_KIND: begin
        uc.cond   = C_KIND;
        uc.target = S_FIN;
      end
      S_SPAN_MUL: uc.mul_sel = MS_SPAN;
      default: uc.cond = C_FIN;
    endcase
    return uc;
  endfunction

endpackage

/* hdl/multiply_carry_prng_uniform.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiply_carry_prng_uniform
// Five-word multiply-with-carry generator run by a microprogrammed sequencer
// over one shared 32x32 multiplier, with reseed and bounded integer draws.
// ----------------------------------------------------------------------------
// Draw: a generator step (lag products on the shared multiplier, commit), kind
// test, range multiply, output load (held off while an untaken result waits);
// the next request is taken once the result is loaded. Equal bounds: load only.
// Reseed: 5 seed passes, 19 warm-up steps, then finish.
// One request at a time; a finished result may wait while the next is taken.
// Reset runs the zero-seed program with in_tready low.
module multiply_carry_prng_uniform
  import mcprng_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // seed_value[31:0], range_low[63:32], range_high[95:64]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // draw_value[31:0], raw_word[63:32]
  output logic        out_tuser   // seed_ack
);

  logic [WORD_W-1:0] gw_r [NWORDS];
  logic [WORD_W-1:0] gw_nxt [NWORDS];
  logic [WORD_W-1:0] s_r, s_nxt;
  logic [WORD_W-1:0] lo_r, lo_nxt;
  logic [WORD_W-1:0] span_r, span_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic              busy_r, busy_nxt;
  logic              quiet_r, quiet_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [63:0]       odata_r, odata_nxt;
  logic              ouser_r, ouser_nxt;

  ucode_t            uc;
  logic [WORD_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] sum;
  logic [WORD_W-1:0] s_dec;
  logic [WORD_W-1:0] req_seed, req_lo, req_hi;
  logic              accept;

  assign req_seed = in_tdata[31:0];
  assign req_lo   = in_tdata[63:32];
  assign req_hi   = in_tdata[95:64];

  assign in_tready  = !busy_r;
  assign accept     = in_tvalid && !busy_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  assign uc    = ucode_rom(pc_r);
  assign sum   = acc_r + prod_r;
  assign s_dec = prod_r[WORD_W-1:0] - WORD_W'(1);

  always_comb begin
    mul_a = gw_r[0];
    mul_b = '0;
    case (uc.mul_sel)
      MS_SEED: begin
        mul_a = s_r;
        mul_b = SEED_MULT;
      end
      MS_W3: begin
        mul_a = gw_r[3];
        mul_b = COEF_W3;
      end
      MS_W2: begin
        mul_a = gw_r[2];
        mul_b = COEF_W2;
      end
      MS_W1: begin
        mul_a = gw_r[1];
        mul_b = COEF_W1;
      end
      MS_W0: begin
        mul_a = gw_r[0];
        mul_b = COEF_W0;
      end
      MS_SPAN: begin
        mul_a = gw_r[0];
        mul_b = span_r;
      end
      default: begin
        mul_a = gw_r[0];
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    gw_nxt     = gw_r;
    s_nxt      = s_r;
    lo_nxt     = lo_r;
    span_nxt   = span_r;
    prod_nxt   = prod_r;
    acc_nxt    = acc_r;
    pc_nxt     = pc_r;
    cnt_nxt    = cnt_r;
    mode_nxt   = mode_r;
    busy_nxt   = busy_r;
    quiet_nxt  = quiet_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;

    if (busy_r) begin
      if (uc.mul_sel != MS_NONE) begin
        prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
      end

      case (uc.acc_op)
        ACC_LOAD: acc_nxt = PROD_W'(gw_r[4]);
        ACC_ADD:  acc_nxt = sum;
        default:  acc_nxt = acc_r;
      endcase

      // shift seed words down, new word enters at the top
      if (uc.seed_wr) begin
        s_nxt = s_dec;
        for (int k = 0; k < NWORDS - 1; k++) begin
          gw_nxt[k] = gw_r[k+1];
        end
        gw_nxt[NWORDS-1] = s_dec;
      end

      // advance the generator: lags up, new word in 0, carry in 4
      if (uc.commit) begin
        gw_nxt[3] = gw_r[2];
        gw_nxt[2] = gw_r[1];
        gw_nxt[1] = gw_r[0];
        gw_nxt[0] = sum[WORD_W-1:0];
        gw_nxt[4] = sum[PROD_W-1:WORD_W];
      end

      unique case (uc.cond)
        C_NEXT: pc_nxt = pc_r + PC_W'(1);
        C_LOOP: begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CNT_W'(1);
            pc_nxt  = uc.target;
          end else begin
            pc_nxt = pc_r + PC_W'(1);
            if (uc.reload) begin
              cnt_nxt = WARM_LAST;
            end
          end
        end
        C_KIND: pc_nxt = (mode_r == MODE_SEED) ? uc.target : pc_r + PC_W'(1);
        C_FIN: begin
          if (quiet_r) begin
            busy_nxt  = 1'b0;
            quiet_nxt = 1'b0;
          end else if (!ovalid_r || out_tready) begin
            busy_nxt   = 1'b0;
            ovalid_nxt = 1'b1;
            unique case (mode_r)
              MODE_DRAW: begin
                odata_nxt = {gw_r[0], prod_r[PROD_W-1:WORD_W] + lo_r};
                ouser_nxt = 1'b0;
              end
              MODE_EQUAL: begin
                odata_nxt = {{WORD_W{1'b0}}, lo_r};
                ouser_nxt = 1'b0;
              end
              default: begin
                odata_nxt = '0;
                ouser_nxt = 1'b1;
              end
            endcase
          end
        end
      endcase
    end else if (accept) begin
      busy_nxt = 1'b1;
      s_nxt    = req_seed;
      lo_nxt   = req_lo;
      span_nxt = req_hi - req_lo + WORD_W'(1);
      if (in_tuser == REQ_SEED) begin
        mode_nxt = MODE_SEED;
        cnt_nxt  = SEED_LAST;
        pc_nxt   = S_SEED_MUL;
      end else if (req_hi == req_lo) begin
        mode_nxt = MODE_EQUAL;
        pc_nxt   = S_FIN;
      end else begin
        mode_nxt = MODE_DRAW;
        cnt_nxt  = '0;
        pc_nxt   = S_GEN_W3;
      end
    end
  end

  always_ff @(posedge clk) begin
    gw_r    <= gw_nxt;
    lo_r    <= lo_nxt;
    span_r  <= span_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
    if (!rst_n) begin
      s_r      <= '0;
      pc_r     <= S_SEED_MUL;
      cnt_r    <= SEED_LAST;
      mode_r   <= MODE_SEED;
      busy_r   <= 1'b1;
      quiet_r  <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      s_r      <= s_nxt;
      pc_r     <= pc_nxt;
      cnt_r    <= cnt_nxt;
      mode_r   <= mode_nxt;
      busy_r   <= busy_nxt;
      quiet_r  <= quiet_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

/* test/multiply_carry_prng_uniform_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiply_carry_prng_uniform_test
// Drives reseed and draw requests through the stream ports: a table of corner
// requests, then a randomised mix with bursty input and a stalling output.
// Each result word is compared with a local five-word multiply-with-carry
// generator kept in step with accepted requests, or with a typed row's result.
// ----------------------------------------------------------------------------
module multiply_carry_prng_uniform_test
  import mcprng_pkg::*;
();

  localparam logic [31:0] SEED_FACTOR  = 32'd29943829;
  localparam int          GEN_WORDS    = 5;
  localparam int          WARMUP_STEPS = 19;
  localparam int          RANDOM_ITEMS = 900;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          IDLE_LIMIT   = 3000;
  localparam int          ROWS         = 21;

  typedef struct packed {
    logic        kind;
    logic [31:0] seed;
    logic [31:0] lo;
    logic [31:0] hi;
  } draw_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] word;
    logic        ack;
  } draw_res_t;

  typedef struct packed {
    draw_req_t req;
    logic      typed;
    draw_res_t res;
  } table_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;

  logic [31:0] mwc_words [GEN_WORDS];
  draw_res_t   pending_results [$];
  int          mismatches   = 0;
  int          idle_cycles  = 0;
  int          burst_left   = 1;
  bit          hold_request = 1'b0;

  table_row_t directed_rows [ROWS] = '{
    '{'{REQ_DRAW, 32'h0,        32'h0,        32'h0       }, 1'b1, '{32'h0,        32'h0, 1'b0}},
    '{'{REQ_DRAW, 32'h0,        32'h0,        32'h1       }, 1'b0, '{32'h0,        32'h0, 1'b0}},
    '{'{REQ_DRAW, 32'h0,        32'h8000_0000, 32'h7fff_ffff}, 1'b0, '{32'h0,      32'h0, 1'b0}},
    '{'{REQ_DRAW, 32'h0,        32'h7fff_ffff, 32'h8000_0000}, 1'b0, '{32'h0,      32'h0, 1'b0}},
    '{'{REQ_DRAW, 32'h0,        32'h8000_0000, 32'h8000_0000}, 1'b1,
      '{32'h8000_0000, 32'h0, 1'b0}},
    '{'{REQ_DRAW, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b1,
      '{32'h7fff_ffff, 32'h0, 1'b0}},
    '{'{REQ_DRAW, 32'h0,        32'hffff_ffff, 32'hffff_ffff}, 1'b1,
      '{32'hffff_ffff, 32'h0, 1'b0}},
    '{'{REQ_SEED, 32'h0,        32'hffff_ffff, 32'hffff_ffff}, 1'b1, '{32'h0,      32'h0, 1'b1}},
    '{'{REQ_DRAW, 32'h0,        32'h0,        32'h9       }, 1'b0, '{32'h0,        32'h0, 1'b0}},
    '{'{REQ_SEED, 32'hffff_ffff, 32'h0,       32'h0       }, 1'b1, '{32'h0,        32'h0, 1'b1}},
    '{'{REQ_DRAW, 32'h0,        32'hffff_fffb, 32'h5       }, 1'b0, '{32'h0,       32'h0, 1'b0}},
    '{'{REQ_SEED, 32'h1,        32'h0,        32'h0       }, 1'b1, '{32'h0,        32'h0, 1'b1}},
    '{'{REQ_DRAW, 32'h0,        32'h0,        32'hffff_ffff}, 1'b0, '{32'h0,       32'h0, 1'b0}},
    '{'{REQ_DRAW, 32'h0,        32'h1,        32'h0       }, 1'b0, '{32'h0,        32'h0, 1'b0}},
    '{'{REQ_DRAW, 32'h0,        32'h8000_0000, 32'h8000_0001}, 1'b0, '{32'h0,      32'h0, 1'b0}},
    '{'{REQ_SEED, 32'h8000_0000, 32'h0,       32'h0       }, 1'b1, '{32'h0,        32'h0, 1'b1}},
    '{'{REQ_DRAW, 32'h0,        32'h0,        32'h7fff_ffff}, 1'b0, '{32'h0,       32'h0, 1'b0}},
    '{'{REQ_DRAW, 32'h0,        32'hffff_ffff, 32'h0       }, 1'b0, '{32'h0,       32'h0, 1'b0}},
    '{'{REQ_SEED, 32'ha5a5_a5a5, 32'h0,       32'h0       }, 1'b1, '{32'h0,        32'h0, 1'b1}},
    '{'{REQ_DRAW, 32'h0,        32'h1234_5678, 32'h1234_5678}, 1'b1,
      '{32'h1234_5678, 32'h0, 1'b0}},
    '{'{REQ_DRAW, 32'h5a5a_5a5a, 32'h0,       32'h1       }, 1'b0, '{32'h0,        32'h0, 1'b0}}
  };

  multiply_carry_prng_uniform u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] mwc_next_word();
    logic [63:0] acc;
    acc = 64'd2111111111 * mwc_words[3] + 64'd1492 * mwc_words[2]
        + 64'd1776 * mwc_words[1] + 64'd5115 * mwc_words[0] + mwc_words[4];
    mwc_words[3] = mwc_words[2];
    mwc_words[2] = mwc_words[1];
    mwc_words[1] = mwc_words[0];
    mwc_words[4] = acc[63:32];
    mwc_words[0] = acc[31:0];
    return mwc_words[0];
  endfunction

  function automatic void mwc_reseed(input logic [31:0] seed);
    logic [31:0] s;
    s = seed;
    for (int k = 0; k < GEN_WORDS; k++) begin
      s = s * SEED_FACTOR - 32'd1;
      mwc_words[k] = s;
    end
    for (int k = 0; k < WARMUP_STEPS; k++) void'(mwc_next_word());
  endfunction

  function automatic draw_res_t draw_outcome(input draw_req_t r);
    draw_res_t   res;
    logic [31:0] span;
    logic [63:0] prod;
    res = '0;
    if (r.kind == REQ_SEED) begin
      mwc_reseed(r.seed);
      res.ack = 1'b1;
    end else if (r.hi == r.lo) begin
      res.value = r.lo;
    end else begin
      span      = r.hi - r.lo + 32'd1;
      res.word  = mwc_next_word();
      prod      = {32'd0, res.word} * {32'd0, span};
      res.value = prod[63:32] + r.lo;
    end
    return res;
  endfunction

  function automatic draw_req_t random_request();
    draw_req_t   r;
    logic [31:0] corner [4];
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    r.seed = $urandom();
    r.lo   = $urandom();
    r.hi   = $urandom();
    r.kind = ($urandom_range(0, 99) < 8) ? REQ_SEED : REQ_DRAW;
    if (r.kind == REQ_DRAW) begin
      case ($urandom_range(0, 5))
        0: r.hi = r.lo;
        1: r.hi = r.lo + $urandom_range(1, 15);
        2: ;
        3: if ($signed(r.hi) > $signed(r.lo)) {r.lo, r.hi} = {r.hi, r.lo};
        4: begin
          r.lo = corner[$urandom_range(0, 3)];
          r.hi = corner[$urandom_range(0, 3)];
        end
        default: begin
          r.lo = $urandom_range(0, 100);
          r.hi = r.lo + $urandom_range(1, 1000);
        end
      endcase
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic offer_request(input draw_req_t r, input logic typed,
                               input draw_res_t typed_res);
    draw_res_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {r.hi, r.lo, r.seed};
    do @(posedge clk); while (!in_tready);
    predicted = draw_outcome(r);
    pending_results = {pending_results, (typed ? typed_res : predicted)};
  endtask

  task automatic pace_sender();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
    end
  endtask

  task automatic await_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    mwc_reseed(32'd0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
      pace_sender();
    end
    await_results();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_request = 1'b1;
      if (n == 600) await_results();
      offer_request(random_request(), 1'b0, '0);
      pace_sender();
    end
    await_results();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("words never returned", 32'(pending_results.size()), 32'd0);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver: switch stall pattern at random intervals, long hold-off on request
  initial begin
    int mode;
    int phase;
    mode  = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (phase == 0) begin
          mode  = $urandom_range(0, 3);
          phase = $urandom_range(16, 96);
        end
        phase--;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    draw_res_t got;
    draw_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[63:32], out_tuser};
      if (pending_results.size() == 0) begin
        flag_mismatch("word with nothing pending", got.value, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value) flag_mismatch("draw_value", got.value, want.value);
        if (got.word !== want.word) flag_mismatch("raw_word", got.word, want.word);
        if (got.ack !== want.ack)
          flag_mismatch("seed_ack", 32'(got.ack), 32'(want.ack));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
